// ----- rtl/lru_pr_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared widths, defaults, datapath commands and status for the LRU core.
// ----------------------------------------------------------------------------
package lru_pr_pkg;

  // Default geometry, handed down from the top level as parameters.
  localparam int FRAMES_DEF    = 4;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed widths of the ports.
  localparam int PAGE_PORT_W   = 16;
  localparam int FAULT_W       = 16;
  localparam int FILLED_W      = 3;
  localparam int CFG_W         = 3;

  // Frame limit after reset.
  localparam logic [CFG_W-1:0] ACTIVE_FRAMES_RST = 3'd4;

  // Commands from the controller to the datapath.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP,
    CMD_HIT,
    CMD_EVICT,
    CMD_INSERT
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic match;
    logic last;
    logic full;
  } dp_status_t;

endpackage

// ----- rtl/lru_pr_ctrl.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement controller
// Sequences the walk over the recency list, one position per cycle.
// ----------------------------------------------------------------------------
module lru_pr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  lru_pr_pkg::dp_status_t status,
  output lru_pr_pkg::dp_cmd_t  cmd,
  output logic                 busy
);
  import lru_pr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INSERT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd       = CMD_LOAD;
          state_nxt = status.count_zero ? ST_INSERT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.match) begin
          cmd       = CMD_HIT;
          state_nxt = ST_IDLE;
        end else if (status.last && status.full) begin
          cmd       = CMD_EVICT;
          state_nxt = ST_IDLE;
        end else if (status.last) begin
          cmd       = CMD_STEP;
          state_nxt = ST_INSERT;
        end else begin
          cmd       = CMD_STEP;
        end
      end
      ST_INSERT: begin
        cmd       = CMD_INSERT;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ----- rtl/lru_pr_datapath.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement datapath
// Recency memory, walk registers, counters and the registered result.
// ----------------------------------------------------------------------------
module lru_pr_datapath #(
  parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lru_pr_pkg::dp_cmd_t                  cmd,
  output lru_pr_pkg::dp_status_t               status,
  input  logic [lru_pr_pkg::PAGE_PORT_W-1:0]   in_page_number,
  input  logic                                 cfg_wr_en,
  input  logic [lru_pr_pkg::CFG_W-1:0]         cfg_wr_data,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic                                 out_evicted_valid,
  output logic [lru_pr_pkg::PAGE_PORT_W-1:0]   out_evicted_page,
  output logic [lru_pr_pkg::FAULT_W-1:0]       out_fault_total,
  output logic [lru_pr_pkg::FILLED_W-1:0]      out_frames_filled
);
  import lru_pr_pkg::*;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);

  logic [PAGE_BITS-1:0] mem [FRAMES];
  logic [PAGE_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]     rd_addr;

  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] carry_r;
  logic [IDX_W-1:0]     idx_r;
  logic [CNT_W-1:0]     count_r;
  logic [FAULT_W-1:0]   fault_r;
  logic [CFG_W-1:0]     active_r;
  logic [CNT_W-1:0]     limit;

  logic                   out_valid_r;
  logic                   out_hit_r;
  logic                   out_ev_valid_r;
  logic [PAGE_PORT_W-1:0] out_ev_page_r;
  logic [FAULT_W-1:0]     out_fault_r;
  logic [FILLED_W-1:0]    out_filled_r;

  logic                 wr_en;
  logic                 finish;
  logic                 miss;
  logic [FAULT_W-1:0]   fault_nxt;
  logic [CNT_W-1:0]     count_nxt;

  // Out-of-range limits are clamped to the range one to FRAMES.
  always_comb begin
    if (active_r == '0) begin
      limit = CNT_W'(1);
    end else if (int'(active_r) > FRAMES) begin
      limit = CNT_W'(FRAMES);
    end else begin
      limit = CNT_W'(active_r);
    end
  end

  assign status.count_zero = (count_r == '0);
  assign status.match      = (rd_data_r == page_r);
  assign status.last       = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign status.full       = (count_r >= limit);

  assign rd_addr = (cmd == CMD_LOAD) ? '0 : IDX_W'(idx_r + 1'b1);
  assign wr_en   = (cmd == CMD_STEP) || (cmd == CMD_HIT) ||
                   (cmd == CMD_EVICT) || (cmd == CMD_INSERT);
  assign finish  = (cmd == CMD_HIT) || (cmd == CMD_EVICT) || (cmd == CMD_INSERT);
  assign miss    = (cmd == CMD_EVICT) || (cmd == CMD_INSERT);

  assign fault_nxt = (miss && (fault_r != '1)) ? fault_r + FAULT_W'(1) : fault_r;
  assign count_nxt = (cmd == CMD_INSERT) ? count_r + CNT_W'(1) : count_r;

  // The displaced entry moves one place down as the new page walks forward.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= carry_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fault_r     <= '0;
      active_r    <= ACTIVE_FRAMES_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
      count_r     <= count_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= finish;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        page_r  <= PAGE_BITS'(in_page_number);
        carry_r <= PAGE_BITS'(in_page_number);
        idx_r   <= '0;
      end
      CMD_STEP: begin
        carry_r <= rd_data_r;
        idx_r   <= IDX_W'(idx_r + 1'b1);
      end
      default: begin
      end
    endcase
    if (finish) begin
      out_hit_r      <= (cmd == CMD_HIT);
      out_ev_valid_r <= (cmd == CMD_EVICT);
      out_ev_page_r  <= (cmd == CMD_EVICT) ? PAGE_PORT_W'(rd_data_r) : '0;
      out_fault_r    <= fault_nxt;
      out_filled_r   <= FILLED_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = out_fault_r;
  assign out_frames_filled = out_filled_r;

endmodule

// ----- rtl/lru_page_replacement_core.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement core
// Tracks resident pages in recency order and reports hits, faults and evictions.
// ----------------------------------------------------------------------------
// Usage. A page reference is transferred in at a rising edge where start is
// high and busy is low; in_page_number is sampled then. Busy stays high while
// the reference is processed. The result is transferred out on the out_ ports
// during the single cycle in which out_valid is high; the receiver cannot
// stall, so it must take the result in that cycle. A new reference may be
// started in the very cycle in which out_valid is high.
// Timing. The recency list is walked one frame position per cycle through
// a memory with one read and one write port. A hit ends the walk at the
// matching position; a miss walks to the last resident page, which is
// evicted if the list is full, else the new page goes into a free frame.
// The frame limit is set through cfg_wr_en and cfg_wr_data; the user must
// see that it is written only while the core is idle, as the core itself
// does not enforce this. Reset (rst_n low, synchronous) empties the list,
// clears the fault count and sets the frame limit to four.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
  parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lru_pr_pkg::PAGE_PORT_W-1:0]   in_page_number,
  input  logic                                 cfg_wr_en,
  input  logic [lru_pr_pkg::CFG_W-1:0]         cfg_wr_data,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic                                 out_evicted_valid,
  output logic [lru_pr_pkg::PAGE_PORT_W-1:0]   out_evicted_page,
  output logic [lru_pr_pkg::FAULT_W-1:0]       out_fault_total,
  output logic [lru_pr_pkg::FILLED_W-1:0]      out_frames_filled
);
  import lru_pr_pkg::*;

  // The controller issues commands and holds only its state and busy flag; all other storage sits in the datapath.
  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller acts on start only in its idle state, so a start seen while
  // busy is simply ignored.
  lru_pr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the recency memory, the walk registers, the resident
  // and fault counters, the frame limit and the registered result.
  lru_pr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_page_number    (in_page_number),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .out_frames_filled (out_frames_filled)
  );

endmodule
